// ===== design/ols_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Character codes, scan modes and result kinds for the order line splitter.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h00;

  // scan modes
  localparam logic [1:0] MODE_LINE       = 2'd0;
  localparam logic [1:0] MODE_LINE_BS    = 2'd1;
  localparam logic [1:0] MODE_COMMENT    = 2'd2;
  localparam logic [1:0] MODE_COMMENT_BS = 2'd3;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef logic [1:0] mode_t;

  // whitespace: HT, LF, VT, FF, CR and space
  function automatic logic is_space(input logic [7:0] b);
    is_space = ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
  endfunction

endpackage : ols_pkg
`default_nettype wire

// ===== design/order_line_splitter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// order_line_splitter
// Splits a byte stream of order text into order characters and end markers.
// ----------------------------------------------------------------------------
// Each accepted byte queues its results, which leave one per free output
//   slot. A byte that turns a pending backslash literal, or ends the input
//   with n whitespace bytes held, first sends the backslash and the n held
//   bytes (read from memory), then its own result, then a final end marker.
//   No new byte is taken until the queue is empty; output stalls hold it.
//   With no drain the first result is valid the cycle after the transfer.
// Reset: synchronous, active high; the held whitespace memory is not cleared.
module order_line_splitter #(
  parameter int MAX_HELD = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [7:0]      out_char,
  output logic            last_of_run
);
  import ols_pkg::*;

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BS   = 3'd1;
  localparam logic [2:0] S_HELD = 3'd2;
  localparam logic [2:0] S_R    = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  // architectural scan state
  mode_t          mode, mode_next;
  logic           order_started, order_started_next;
  logic [CW-1:0]  held_count, held_count_next;

  // held whitespace memory, one write and one registered read port
  logic [7:0]     held_mem [MAX_HELD];
  logic [7:0]     rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  // sequencer registers
  logic [2:0]     seq, seq_next;
  logic [7:0]     byte_q;
  logic [CW-1:0]  drain_cnt;
  logic [AW-1:0]  idx;
  logic           has_r_q, r_end_q, end_q;

  // decode of the incoming byte
  logic           in_fire, free;
  logic           is_nl, is_bsl, is_semi, is_sp;
  logic           pre_drain, post_drain, drain, store, line_proc;
  logic           has_r, r_end, fin_end;
  logic [CW-1:0]  drain_n;
  logic           idx_last;

  // result to load into the output register
  logic           emit, e_kind, e_last;
  logic [7:0]     e_char;

  // The output slot is free when empty or being drained this cycle.
  assign free     = !out_valid || out_ready;
  assign in_ready = (seq == S_IDLE) && free;
  assign in_fire  = in_valid && in_ready;

  assign is_nl   = (in_byte == CH_NL);
  assign is_bsl  = (in_byte == CH_BSL);
  assign is_semi = (in_byte == CH_SEMI);
  assign is_sp   = is_space(in_byte);

  // Work out the whole effect of one byte: new scan state, whether a literal
  // backslash drain is needed, the byte's own result and the final end marker.
  always_comb begin
    mode_next          = mode;
    order_started_next = order_started;
    held_count_next    = held_count;
    pre_drain          = 1'b0;
    store              = 1'b0;
    line_proc          = 1'b0;
    has_r              = 1'b0;
    r_end              = 1'b0;
    case (mode)
      MODE_LINE: begin
        line_proc = 1'b1;
      end
      MODE_LINE_BS: begin
        if (is_nl) begin
          // line join: drop backslash and held whitespace
          mode_next       = MODE_LINE;
          held_count_next = '0;
        end else if (is_sp && (held_count < CW'(MAX_HELD))) begin
          store           = 1'b1;
          held_count_next = held_count + 1'b1;
        end else begin
          // backslash turns literal; the drain sends it and starts an order
          pre_drain          = 1'b1;
          line_proc          = 1'b1;
          mode_next          = MODE_LINE;
          held_count_next    = '0;
          order_started_next = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (is_nl) begin
          mode_next = MODE_LINE;
        end else if (is_bsl) begin
          mode_next       = MODE_COMMENT_BS;
          held_count_next = '0;
        end
      end
      default: begin
        if (is_nl) begin
          mode_next       = MODE_COMMENT;
          held_count_next = '0;
        end else if (is_bsl) begin
          held_count_next = '0;
        end else if (is_sp && (held_count < CW'(MAX_HELD))) begin
          held_count_next = held_count + 1'b1;
        end else begin
          mode_next       = MODE_COMMENT;
          held_count_next = '0;
        end
      end
    endcase

    if (line_proc) begin
      if (is_nl) begin
        has_r              = order_started_next;
        r_end              = 1'b1;
        order_started_next = 1'b0;
      end else if (is_bsl) begin
        mode_next       = MODE_LINE_BS;
        held_count_next = '0;
      end else if (is_semi) begin
        has_r              = order_started_next;
        r_end              = 1'b1;
        order_started_next = 1'b0;
        mode_next          = MODE_COMMENT;
      end else if (is_sp && !order_started_next) begin
        // drop leading whitespace
      end else begin
        has_r              = 1'b1;
        order_started_next = 1'b1;
      end
    end

    // end of input: a backslash with whitespace held goes out literally
    post_drain = end_of_input && (mode_next == MODE_LINE_BS) && (held_count_next != '0);
    fin_end    = end_of_input &&
                 ((mode_next == MODE_LINE) || (mode_next == MODE_LINE_BS)) &&
                 (order_started_next || post_drain);
    drain      = pre_drain || post_drain;
    drain_n    = pre_drain ? held_count : held_count_next;
  end

  assign idx_last = ((CW'(idx) + CW'(1)) == drain_cnt);

  // Sequencer: emit the queued results one per free output slot.
  always_comb begin
    seq_next = seq;
    emit     = 1'b0;
    e_kind   = KIND_CHAR;
    e_char   = CH_ZERO;
    e_last   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    case (seq)
      S_IDLE: begin
        if (in_fire) begin
          if (drain) begin
            seq_next = S_BS;
          end else if (has_r) begin
            emit     = 1'b1;
            e_kind   = r_end ? KIND_END : KIND_CHAR;
            e_char   = r_end ? CH_ZERO : in_byte;
            e_last   = !fin_end;
            seq_next = fin_end ? S_END : S_IDLE;
          end else if (fin_end) begin
            emit   = 1'b1;
            e_kind = KIND_END;
            e_last = 1'b1;
          end
        end
      end
      S_BS: begin
        if (free) begin
          emit    = 1'b1;
          e_char  = CH_BSL;
          e_last  = (drain_cnt == '0) && !has_r_q && !end_q;
          rd_en   = 1'b1;
          rd_addr = '0;
          if (drain_cnt != '0) begin
            seq_next = S_HELD;
          end else if (has_r_q) begin
            seq_next = S_R;
          end else if (end_q) begin
            seq_next = S_END;
          end else begin
            seq_next = S_IDLE;
          end
        end
      end
      S_HELD: begin
        if (free) begin
          emit   = 1'b1;
          e_char = rd_data;
          e_last = idx_last && !has_r_q && !end_q;
          if (!idx_last) begin
            // prefetch the next held byte
            rd_en   = 1'b1;
            rd_addr = idx + 1'b1;
          end else if (has_r_q) begin
            seq_next = S_R;
          end else if (end_q) begin
            seq_next = S_END;
          end else begin
            seq_next = S_IDLE;
          end
        end
      end
      S_R: begin
        if (free) begin
          emit     = 1'b1;
          e_kind   = r_end_q ? KIND_END : KIND_CHAR;
          e_char   = r_end_q ? CH_ZERO : byte_q;
          e_last   = !end_q;
          seq_next = end_q ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (free) begin
          emit     = 1'b1;
          e_kind   = KIND_END;
          e_last   = 1'b1;
          seq_next = S_IDLE;
        end
      end
      default: begin
        seq_next = S_IDLE;
      end
    endcase
  end

  // Scan state: advance on every input transfer; end of input returns to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_LINE;
      order_started <= 1'b0;
      held_count    <= '0;
    end else if (in_fire) begin
      if (end_of_input) begin
        mode          <= MODE_LINE;
        order_started <= 1'b0;
        held_count    <= '0;
      end else begin
        mode          <= mode_next;
        order_started <= order_started_next;
        held_count    <= held_count_next;
      end
    end
  end

  // Held whitespace memory.
  always_ff @(posedge clk) begin
    if (in_fire && store) begin
      held_mem[held_count[AW-1:0]] <= in_byte;
    end
    if (rd_en) begin
      rd_data <= held_mem[rd_addr];
    end
  end

  // Sequencer state and the item captured for a drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_q    <= in_byte;
      drain_cnt <= drain_n;
      has_r_q   <= has_r;
      r_end_q   <= r_end;
      end_q     <= fin_end;
    end
    if (rd_en) begin
      idx <= rd_addr;
    end
  end

  // Output register: load on emit, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind    <= e_kind;
      out_char    <= e_char;
      last_of_run <= e_last;
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(MAX_HELD))
    else $error("held count exceeds capacity");

  a_comment_no_order: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_COMMENT || mode == MODE_COMMENT_BS) |-> !order_started)
    else $error("order still open inside a comment");

  a_end_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_END)) |-> (out_char == CH_ZERO))
    else $error("end marker carries a character");

  a_end_state_emits: assert property (@(posedge clk) disable iff (rst)
    (seq == S_END && free) |=> (out_valid && out_kind == KIND_END && last_of_run))
    else $error("final end marker not emitted");

  a_held_nonempty: assert property (@(posedge clk) disable iff (rst)
    (seq == S_HELD) |-> (drain_cnt != '0))
    else $error("drain of held bytes with nothing held");
`endif

endmodule : order_line_splitter
`default_nettype wire

// ===== dv/tb_order_line_splitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_order_line_splitter
// Self-checking bench for the order line splitter. Feeds directed and random
// order text through the byte channel and compares every result transfer
// against an in-bench model of the line, comment and backslash scanning.
// ----------------------------------------------------------------------------
module tb_order_line_splitter;
  import ols_pkg::*;

  localparam int HELD_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last_flag;
  } order_res_t;

  // Model of the splitter plus the queue of results it still owes.
  class order_scoreboard;
    mode_t       mode;
    bit          started;
    logic [7:0]  held [HELD_DEPTH];
    int unsigned held_n;
    order_res_t  owed_q [$];
    order_res_t  batch [$];
    int          errors;

    function new();
      reset_state();
      errors = 0;
    endfunction

    function void reset_state();
      mode    = MODE_LINE;
      started = 1'b0;
      held_n  = 0;
    endfunction

    function bit is_ws(logic [7:0] b);
      return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
    endfunction

    function void emit(logic kind, logic [7:0] ch);
      order_res_t r;
      r.kind      = kind;
      r.ch        = (kind == KIND_END) ? CH_ZERO : ch;
      r.last_flag = 1'b0;
      batch.push_back(r);
    endfunction

    function void send_ch(logic [7:0] ch);
      emit(KIND_CHAR, ch);
      started = 1'b1;
    endfunction

    function void close_order();
      if (started) emit(KIND_END, CH_ZERO);
      started = 1'b0;
    endfunction

    // pending backslash turns literal: send it and the whitespace held after it
    function void release_backslash();
      send_ch(CH_BSL);
      for (int i = 0; i < held_n; i++) send_ch(held[i]);
      held_n = 0;
      mode   = MODE_LINE;
    endfunction

    function void line_char(logic [7:0] b);
      if (b == CH_NL) begin
        close_order();
      end else if (b == CH_BSL) begin
        mode   = MODE_LINE_BS;
        held_n = 0;
      end else if (b == CH_SEMI) begin
        close_order();
        mode = MODE_COMMENT;
      end else if (!(is_ws(b) && !started)) begin
        send_ch(b);
      end
    endfunction

    function void note_input(logic [7:0] b, logic eoi);
      order_res_t r;
      batch.delete();
      case (mode)
        MODE_LINE: line_char(b);
        MODE_LINE_BS: begin
          if (b == CH_NL) begin
            mode   = MODE_LINE;
            held_n = 0;
          end else if (is_ws(b) && held_n < HELD_DEPTH) begin
            held[held_n] = b;
            held_n++;
          end else begin
            release_backslash();
            line_char(b);
          end
        end
        MODE_COMMENT: begin
          if (b == CH_NL) begin
            mode = MODE_LINE;
          end else if (b == CH_BSL) begin
            mode   = MODE_COMMENT_BS;
            held_n = 0;
          end
        end
        default: begin
          if (b == CH_NL) begin
            mode   = MODE_COMMENT;
            held_n = 0;
          end else if (b == CH_BSL) begin
            held_n = 0;
          end else if (is_ws(b) && held_n < HELD_DEPTH) begin
            held_n++;
          end else begin
            mode   = MODE_COMMENT;
            held_n = 0;
          end
        end
      endcase
      if (eoi) begin
        if (mode == MODE_LINE_BS && held_n > 0) release_backslash();
        if (mode == MODE_LINE || mode == MODE_LINE_BS) close_order();
        reset_state();
      end
      for (int i = 0; i < batch.size(); i++) begin
        r           = batch[i];
        r.last_flag = (i == batch.size() - 1);
        owed_q.push_back(r);
      end
    endfunction

    function void check_result(logic kind, logic [7:0] ch, logic last_flag);
      order_res_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d char %02h last %0d",
                 $time, kind, ch, last_flag);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (kind !== exp.kind) begin
        $display("%0t: out_kind mismatch: expected %0d, got %0d", $time, exp.kind, kind);
        errors++;
      end
      if (ch !== exp.ch) begin
        $display("%0t: out_char mismatch: expected %02h, got %02h", $time, exp.ch, ch);
        errors++;
      end
      if (last_flag !== exp.last_flag) begin
        $display("%0t: last_of_run mismatch: expected %0d, got %0d",
                 $time, exp.last_flag, last_flag);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire        out_kind;
  wire  [7:0] out_char;
  wire        last_of_run;

  order_scoreboard sb;
  int sender_idle = 0;   // percent of cycles the sender holds off
  int recv_stall  = 0;   // percent of cycles the receiver stalls
  int items_sent  = 0;
  int cycle_count = 0;

  order_line_splitter #(.MAX_HELD(HELD_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_input(end_of_input),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_order_line_splitter: errors");
      $finish;
    end
  end

  // Receive side: check each result transfer, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_kind, out_char, last_of_run);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Present one byte, hold it until the transfer, then hand it to the model.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, eoi);
    items_sent++;
  endtask

  // Hold off the sender until every owed result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(4))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(25));
    if (r < 85) return 8'h30 + 8'($urandom_range(9));
    if (r < 95) return 8'h21 + 8'($urandom_range(14));
    return 8'($urandom_range(255));
  endfunction

  task automatic put_ws(input int n);
    repeat (n) send_byte(pick_ws(), 1'b0);
  endtask

  task automatic put_word();
    repeat ($urandom_range(1, 6)) send_byte(pick_char(), 1'b0);
  endtask

  // Length of a whitespace run after a backslash: mostly short, sometimes
  // just under, at or past the hold depth.
  function automatic int held_run();
    if ($urandom_range(7) == 0) return $urandom_range(HELD_DEPTH - 2, HELD_DEPTH + 1);
    return $urandom_range(0, 3);
  endfunction

  // One line of order text, mostly well formed, sometimes noise or broken.
  task automatic send_random_line();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
    end else if (r < 12) begin
      send_byte(CH_BSL, 1'b1);
    end else if (r < 17) begin
      // empty or whitespace-only line
      put_ws($urandom_range(0, 3));
      send_byte(CH_NL, $urandom_range(5) == 0);
    end else begin
      put_ws($urandom_range(0, 2));
      put_word();
      repeat ($urandom_range(0, 2)) begin
        put_ws($urandom_range(1, 2));
        put_word();
      end
      if ($urandom_range(99) < 30) begin
        // continuation, sometimes broken by a stray character
        send_byte(CH_BSL, 1'b0);
        put_ws(held_run());
        if ($urandom_range(3) == 0) send_byte(pick_char(), 1'b0);
        else send_byte(CH_NL, 1'b0);
        put_ws($urandom_range(0, 1));
        put_word();
      end
      if ($urandom_range(99) < 30) begin
        // comment, sometimes continued onto the next line
        send_byte(CH_SEMI, 1'b0);
        if ($urandom_range(1) == 0) put_word();
        if ($urandom_range(2) == 0) begin
          send_byte(CH_BSL, 1'b0);
          put_ws(held_run());
          if ($urandom_range(3) == 0) send_byte(pick_char(), 1'b0);
          else send_byte(CH_NL, 1'b0);
          put_word();
        end
      end
      r = $urandom_range(99);
      if (r < 6) send_byte(pick_char(), 1'b1);
      else if (r < 12) send_byte(CH_NL, 1'b1);
      else if (r < 16) send_byte(CH_BSL, 1'b1);
      else send_byte(CH_NL, 1'b0);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed text, no idling.
    send_byte(8'h20, 1'b0);        // leading space, dropped
    send_byte(CH_ZERO, 1'b0);      // zero byte is an ordinary character
    send_byte(8'hFF, 1'b0);
    send_byte(CH_BSL, 1'b0);       // backslash broken by a character
    send_byte(8'h09, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(CH_BSL, 1'b0);       // backslash joining the next line
    send_byte(8'h0D, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(CH_SEMI, 1'b0);      // end order, open comment
    send_byte(CH_BSL, 1'b0);       // comment continued
    send_byte(8'h20, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_BSL, 1'b0);       // backslash then backslash
    send_byte(CH_BSL, 1'b0);
    send_byte(CH_SEMI, 1'b0);      // pending backslash broken by a semicolon
    send_byte(CH_NL, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(CH_BSL, 1'b1);       // bare backslash at end of input, dropped
    send_byte(CH_BSL, 1'b0);
    send_byte(8'h0C, 1'b1);        // backslash with held space at end, literal
    send_byte(8'h63, 1'b0);
    send_byte(CH_SEMI, 1'b1);      // end of input inside a comment
    drain_results();

    // Random phases: none, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 58; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 58; end
        default: begin sender_idle = 38; recv_stall = 38; end
      endcase
      while (items_sent < 26 + 75 * (phase + 1)) send_random_line();
      drain_results();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb_order_line_splitter: clean");
    else $display("tb_order_line_splitter: errors");
    $finish;
  end

endmodule
